[design/polynomial_add_sub_multiply_defines.svh]
// Assertion macros shared by the polynomial unit.
`ifndef POLYNOMIAL_ADD_SUB_MULTIPLY_DEFINES_SVH
`define POLYNOMIAL_ADD_SUB_MULTIPLY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PASM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("polynomial unit check failed");
`define PASM_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("polynomial unit implication failed");
`else
`define PASM_ASSERT(lbl, clk, rst_n, prop)
`define PASM_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`endif

`endif

[design/pasm_pkg.sv]
// Word types, command codes and control structs of the polynomial unit.
`timescale 1ns / 1ps
package pasm_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned IN_COEF_W = 16;
  localparam int unsigned RES_W    = 40;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL    = 3'd4;

  localparam logic [1:0] LIP_NONE = 2'd0;
  localparam logic [1:0] LIP_A    = 2'd1;
  localparam logic [1:0] LIP_B    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]            command;
    logic signed [IN_COEF_W-1:0] coefficient;
    logic                        final_coefficient;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_coefficient;
    logic                    result_last;
    logic                    error;
  } out_word_t;

  typedef struct packed {
    logic wr_en;
    logic wr_sel;
    logic rd_en;
    logic use_a;
    logic use_b;
    logic term_vld;
    logic acc_clr;
    logic out_sum;
    logic out_acc;
    logic out_err_word;
    logic subtract;
    logic out_last;
    logic out_error;
  } dp_ctrl_t;

  typedef struct packed {
    logic out_free;
    logic pipe_empty;
  } dp_stat_t;

endpackage

[design/polynomial_add_sub_multiply.sv]
// Top level of the polynomial add, subtract and multiply unit.
// Load words are accepted without stall while the unit is idle. Add and subtract form each
// result word in a read state and an output state; multiply sums each result word's terms
// on the one shared multiplier, then waits for the pipeline to drain before output.
// Reset is asynchronous, active low: lengths zero, no load open, operand
// stores hold undefined data until written and get no clearing pass.
`timescale 1ns / 1ps
`include "polynomial_add_sub_multiply_defines.svh"
module polynomial_add_sub_multiply #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned COEF_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pasm_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pasm_pkg::out_word_t out_word_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_TERMS);
  localparam int unsigned LEN_W  = $clog2(MAX_TERMS + 1);
  localparam int unsigned RUN_W  = $clog2(2 * MAX_TERMS);

  pasm_pkg::dp_ctrl_t dp_ctrl;
  pasm_pkg::dp_stat_t dp_stat;
  logic [ADDR_W-1:0]  wr_addr, rd_addr_a, rd_addr_b;
  logic [2:0]         dp_out_src;

  pasm_ctrl #(
    .MAX_TERMS(MAX_TERMS),
    .ADDR_W   (ADDR_W),
    .LEN_W    (LEN_W),
    .RUN_W    (RUN_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .ctrl_o     (dp_ctrl),
    .stat_i     (dp_stat),
    .wr_addr_o  (wr_addr),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b)
  );

  pasm_datapath #(
    .MAX_TERMS(MAX_TERMS),
    .COEF_BITS(COEF_BITS),
    .ADDR_W   (ADDR_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dp_ctrl),
    .stat_o     (dp_stat),
    .wr_addr_i  (wr_addr),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .wr_coef_i  (in_word_i.coefficient),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  assign dp_out_src = {dp_ctrl.out_sum, dp_ctrl.out_acc, dp_ctrl.out_err_word};

  `PASM_ASSERT_IMPL(a_out_load_free, clk_i, rst_ni, |dp_out_src, dp_stat.out_free)
  `PASM_ASSERT_IMPL(a_acc_drained, clk_i, rst_ni, dp_ctrl.out_acc, dp_stat.pipe_empty)
  `PASM_ASSERT(a_one_source, clk_i, rst_ni, $onehot0(dp_out_src))
  `PASM_ASSERT_IMPL(a_no_write_busy, clk_i, rst_ni, dp_ctrl.wr_en, !in_stall_o && in_valid_i)

endmodule

[design/pasm_datapath.sv]
// Datapath: operand stores, adder, shared multiplier, accumulator, output register.
`timescale 1ns / 1ps
module pasm_datapath #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned COEF_BITS = 16,
  parameter int unsigned ADDR_W    = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pasm_pkg::dp_ctrl_t                ctrl_i,
  output pasm_pkg::dp_stat_t                stat_o,
  input  logic [ADDR_W-1:0]                 wr_addr_i,
  input  logic [ADDR_W-1:0]                 rd_addr_a_i,
  input  logic [ADDR_W-1:0]                 rd_addr_b_i,
  input  logic signed [pasm_pkg::IN_COEF_W-1:0] wr_coef_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pasm_pkg::out_word_t               out_word_o
);

  localparam int unsigned PROD_W = 2 * COEF_BITS;
  localparam int unsigned RES_W  = pasm_pkg::RES_W;
  localparam int unsigned EXT_W  = (PROD_W > RES_W) ? PROD_W : RES_W;

  logic signed [COEF_BITS-1:0] mem_a_q [MAX_TERMS];
  logic signed [COEF_BITS-1:0] mem_b_q [MAX_TERMS];
  logic signed [COEF_BITS-1:0] wr_coef;
  logic signed [COEF_BITS-1:0] rd_a_q, rd_b_q;
  logic                        use_a_q, use_b_q;
  logic                        v1_q, v2_q;
  logic signed [PROD_W-1:0]    p_q;
  logic signed [EXT_W-1:0]     p_ext;
  logic signed [RES_W-1:0]     acc_q, acc_d;
  logic signed [RES_W-1:0]     a_ext, b_ext, sum;
  pasm_pkg::out_word_t         out_q, out_d;
  logic                        out_vld_q, out_vld_d;
  logic                        out_load;

  assign wr_coef = COEF_BITS'(wr_coef_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && !ctrl_i.wr_sel) begin
      mem_a_q[wr_addr_i] <= wr_coef;
    end
    if (ctrl_i.wr_en && ctrl_i.wr_sel) begin
      mem_b_q[wr_addr_i] <= wr_coef;
    end
    if (ctrl_i.rd_en) begin
      rd_a_q  <= mem_a_q[rd_addr_a_i];
      rd_b_q  <= mem_b_q[rd_addr_b_i];
      use_a_q <= ctrl_i.use_a;
      use_b_q <= ctrl_i.use_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      v1_q      <= ctrl_i.term_vld;
      v2_q      <= v1_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= PROD_W'(rd_a_q) * PROD_W'(rd_b_q);
    acc_q <= acc_d;
    out_q <= out_d;
  end

  assign p_ext = EXT_W'(p_q);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + p_ext[RES_W-1:0];
    end
  end

  assign a_ext = use_a_q ? RES_W'(rd_a_q) : '0;
  assign b_ext = use_b_q ? RES_W'(rd_b_q) : '0;
  assign sum   = ctrl_i.subtract ? (a_ext - b_ext) : (a_ext + b_ext);

  assign out_load = ctrl_i.out_sum || ctrl_i.out_acc || ctrl_i.out_err_word;

  always_comb begin
    out_d = out_q;
    if (ctrl_i.out_sum) begin
      out_d.result_coefficient = sum;
    end else if (ctrl_i.out_acc) begin
      out_d.result_coefficient = acc_q;
    end else if (ctrl_i.out_err_word) begin
      out_d.result_coefficient = '0;
    end
    if (out_load) begin
      out_d.result_last = ctrl_i.out_last;
      out_d.error       = ctrl_i.out_error;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign stat_o.out_free   = !out_vld_q;
  assign stat_o.pipe_empty = !v1_q && !v2_q;
  assign out_valid_o       = out_vld_q;
  assign out_word_o        = out_q;

endmodule

[design/pasm_ctrl.sv]
// Controller: load bookkeeping and the sequencer for add, subtract and multiply runs.
`timescale 1ns / 1ps
module pasm_ctrl #(
  parameter int unsigned MAX_TERMS = 32,
  parameter int unsigned ADDR_W    = 5,
  parameter int unsigned LEN_W     = 6,
  parameter int unsigned RUN_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  pasm_pkg::in_word_t   in_word_i,
  output logic                 in_stall_o,
  output pasm_pkg::dp_ctrl_t   ctrl_o,
  input  pasm_pkg::dp_stat_t   stat_i,
  output logic [ADDR_W-1:0]    wr_addr_o,
  output logic [ADDR_W-1:0]    rd_addr_a_o,
  output logic [ADDR_W-1:0]    rd_addr_b_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ERR  = 7'b0000010,
    S_ARD  = 7'b0000100,
    S_AWR  = 7'b0001000,
    S_MST  = 7'b0010000,
    S_MISS = 7'b0100000,
    S_MFL  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [LEN_W-1:0] la_q, la_d, lb_q, lb_d;
  logic [1:0]       lip_q, lip_d;
  logic             ovf_q, ovf_d;
  logic             err_q, err_d;
  logic             sub_q, sub_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic [RUN_W-1:0] r_q, r_d;

  logic             in_acc, is_load, is_op, load_b, room;
  logic [1:0]       lip_tgt;
  logic [LEN_W-1:0] cur_len, eff_len, max_len, off_a, off_b;
  logic [RUN_W-1:0] la_r, lb_r, run_len, i_lo, i_hi;

  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign load_b  = in_word_i.command == pasm_pkg::CMD_LOAD_B;
  assign is_load = (in_word_i.command == pasm_pkg::CMD_LOAD_A) || load_b;
  assign is_op   = (in_word_i.command == pasm_pkg::CMD_ADD) ||
                   (in_word_i.command == pasm_pkg::CMD_SUB) ||
                   (in_word_i.command == pasm_pkg::CMD_MUL);
  assign lip_tgt = load_b ? pasm_pkg::LIP_B : pasm_pkg::LIP_A;
  assign cur_len = load_b ? lb_q : la_q;
  assign eff_len = (lip_q != lip_tgt) ? '0 : cur_len;
  assign room    = eff_len < LEN_W'(MAX_TERMS);

  assign max_len = (la_q > lb_q) ? la_q : lb_q;
  assign off_a   = max_len - la_q;
  assign off_b   = max_len - lb_q;

  assign la_r    = RUN_W'(la_q);
  assign lb_r    = RUN_W'(lb_q);
  assign run_len = la_r + lb_r - RUN_W'(1);
  assign i_lo    = (r_q >= lb_r) ? (r_q - lb_r + RUN_W'(1)) : '0;
  assign i_hi    = (r_q < la_r) ? r_q : (la_r - RUN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      la_q    <= '0;
      lb_q    <= '0;
      lip_q   <= pasm_pkg::LIP_NONE;
      ovf_q   <= 1'b0;
      err_q   <= 1'b0;
      sub_q   <= 1'b0;
      k_q     <= '0;
      r_q     <= '0;
    end else begin
      state_q <= state_d;
      la_q    <= la_d;
      lb_q    <= lb_d;
      lip_q   <= lip_d;
      ovf_q   <= ovf_d;
      err_q   <= err_d;
      sub_q   <= sub_d;
      k_q     <= k_d;
      r_q     <= r_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    la_d        = la_q;
    lb_d        = lb_q;
    lip_d       = lip_q;
    ovf_d       = ovf_q;
    err_d       = err_q;
    sub_d       = sub_q;
    k_d         = k_q;
    r_d         = r_q;
    ctrl_o      = '0;
    wr_addr_o   = eff_len[ADDR_W-1:0];
    rd_addr_a_o = '0;
    rd_addr_b_o = '0;
    ctrl_o.subtract = sub_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc && is_load) begin
          ctrl_o.wr_en  = room;
          ctrl_o.wr_sel = load_b;
          if (load_b) begin
            lb_d = room ? (eff_len + LEN_W'(1)) : eff_len;
          end else begin
            la_d = room ? (eff_len + LEN_W'(1)) : eff_len;
          end
          ovf_d = ovf_q || !room;
          lip_d = in_word_i.final_coefficient ? pasm_pkg::LIP_NONE : lip_tgt;
        end else if (in_acc && is_op) begin
          lip_d = pasm_pkg::LIP_NONE;
          err_d = ovf_q;
          ovf_d = 1'b0;
          sub_d = in_word_i.command == pasm_pkg::CMD_SUB;
          k_d   = '0;
          r_d   = '0;
          if ((la_q == '0) || (lb_q == '0)) begin
            state_d = S_ERR;
          end else if (in_word_i.command == pasm_pkg::CMD_MUL) begin
            state_d = S_MST;
          end else begin
            state_d = S_ARD;
          end
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          ctrl_o.out_err_word = 1'b1;
          ctrl_o.out_last     = 1'b1;
          ctrl_o.out_error    = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_ARD: begin
        rd_addr_a_o = ADDR_W'(k_q - off_a);
        rd_addr_b_o = ADDR_W'(k_q - off_b);
        if (stat_i.out_free) begin
          ctrl_o.rd_en = 1'b1;
          ctrl_o.use_a = k_q >= off_a;
          ctrl_o.use_b = k_q >= off_b;
          state_d      = S_AWR;
        end
      end
      S_AWR: begin
        ctrl_o.out_sum   = 1'b1;
        ctrl_o.out_last  = k_q == (max_len - LEN_W'(1));
        ctrl_o.out_error = err_q && (k_q == '0);
        k_d              = k_q + LEN_W'(1);
        state_d          = (k_q == (max_len - LEN_W'(1))) ? S_IDLE : S_ARD;
      end
      S_MST: begin
        if (stat_i.out_free) begin
          ctrl_o.acc_clr = 1'b1;
          k_d            = i_lo[LEN_W-1:0];
          state_d        = S_MISS;
        end
      end
      S_MISS: begin
        ctrl_o.rd_en    = 1'b1;
        ctrl_o.term_vld = 1'b1;
        rd_addr_a_o     = k_q[ADDR_W-1:0];
        rd_addr_b_o     = ADDR_W'(r_q - RUN_W'(k_q));
        if (RUN_W'(k_q) == i_hi) begin
          state_d = S_MFL;
        end else begin
          k_d = k_q + LEN_W'(1);
        end
      end
      S_MFL: begin
        if (stat_i.pipe_empty) begin
          ctrl_o.out_acc   = 1'b1;
          ctrl_o.out_last  = r_q == (run_len - RUN_W'(1));
          ctrl_o.out_error = err_q && (r_q == '0);
          r_d              = r_q + RUN_W'(1);
          state_d          = (r_q == (run_len - RUN_W'(1))) ? S_IDLE : S_MST;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
